@@ rtl/csort_pkg.sv @@
// Shared types and constants for the counting sort engine.
// No dependencies; every other file imports this package.
package csort_pkg;

  localparam int NUM_BINS   = 128;
  localparam int COUNT_BITS = 25;
  localparam int KEY_W      = $clog2(NUM_BINS);
  localparam int CFG_W      = 8;
  localparam int CMP_W      = (KEY_W > CFG_W) ? KEY_W : CFG_W;

  localparam logic [CFG_W-1:0] BINS_RESET = CFG_W'(100);

  // Command codes
  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic             empty_res;
  } out_item_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic             count_en;
    logic [KEY_W-1:0] key;
    logic             launch;
    logic [KEY_W-1:0] ptr;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

@@ rtl/csort_cell.sv @@
// One bin of the counting sort chain: a saturating count and a seek token.
// Depends on csort_pkg.
module csort_cell import csort_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [KEY_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  logic             tok_in,
  output logic             tok_out,
  output logic             hit
);

  logic [COUNT_BITS-1:0] count;
  logic                  tok;
  logic                  nonzero;
  logic                  sat;

  assign nonzero = |count;
  assign sat     = &count;

  // Claim the token on a filled bin, else pass it on
  assign hit     = tok & nonzero;
  assign tok_out = tok & ~nonzero;

  // Take the token from the launch decode or the lower neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= (ctl.launch && (ctl.ptr == idx)) | tok_in;
    end
  end

  // Increment on a count transfer for this key, decrement on a claim
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.count_en && (ctl.key == idx)) begin
      if (!sat) begin
        count <= count + COUNT_BITS'(1);
      end
    end else if (hit) begin
      count <= count - COUNT_BITS'(1);
    end
  end

endmodule

@@ rtl/csort_ctrl.sv @@
// Command sequencing, drain pointer, configuration and result register.
// Depends on csort_pkg.
module csort_ctrl import csort_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             any_hit,
  input  logic             chain_end,
  output cell_ctl_t        ctl,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item
);

  state_t           state;
  state_t           state_next;
  logic [CFG_W-1:0] bins_in_use;
  logic [KEY_W-1:0] ptr;
  logic [KEY_W-1:0] scan_idx;
  logic             accept;
  logic             in_range;
  logic             slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && ((in_item.cmd == CMD_COUNT) || slot_free);
  assign accept    = in_valid && in_ready;

  // Every key is below NUM_BINS, so only the register bounds the range
  assign in_range = CMP_W'(in_item.key) < CMP_W'(bins_in_use);

  assign ctl.count_en = accept && (in_item.cmd == CMD_COUNT) && in_range;
  assign ctl.key      = in_item.key;
  assign ctl.launch   = accept && (in_item.cmd == CMD_DRAIN);
  assign ctl.ptr      = ptr;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (ctl.launch) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (any_hit || chain_end) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bins_in_use <= BINS_RESET;
    end else if (cfg_we) begin
      bins_in_use <= cfg_wdata;
    end
  end

  // Follow the token position during a scan
  always_ff @(posedge clk) begin
    if (ctl.launch) begin
      scan_idx <= ptr;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + KEY_W'(1);
    end
  end

  // Drain pointer: move back on a lower count, land on a hit, rewind on empty
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (ctl.count_en && (in_item.key < ptr)) begin
      ptr <= in_item.key;
    end else if (state == ST_SCAN) begin
      if (any_hit) begin
        ptr <= scan_idx;
      end else if (chain_end) begin
        ptr <= '0;
      end
    end
  end

  // Result register: load at scan end, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_SCAN) && (any_hit || chain_end)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      if (any_hit) begin
        out_item.sorted_key <= scan_idx;
        out_item.empty_res  <= 1'b0;
      end else if (chain_end) begin
        out_item.sorted_key <= '0;
        out_item.empty_res  <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/counting_sort_engine_top.sv @@
// Counting sort engine: controller plus a chain of NUM_BINS count cells.
// Depends on csort_pkg, csort_cell and csort_ctrl.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------
//   input    | in_valid / in_ready  | in_item   (cmd, key)
//   output   | out_valid / out_ready| out_item  (sorted_key, empty_res)
//   config   | cfg_we               | cfg_wdata (bins_in_use)
//
// Counts can transfer on every cycle while no drain scan is in progress.
// A drain launches a token at the drain pointer that moves one cell per cycle
// until a filled bin claims it, or it passes the top cell when every bin from
// the pointer up is empty.
// Reset is synchronous and clears all counts at once; no clearing pass.
// A drain is taken only while the result register is free or being emptied.
module counting_sort_engine_top import csort_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  cell_ctl_t           ctl;
  logic [NUM_BINS:0]   tok_chain;
  logic [NUM_BINS-1:0] hits;
  logic                any_hit;

  assign tok_chain[0] = 1'b0;
  assign any_hit      = |hits;

  csort_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .any_hit   (any_hit),
    .chain_end (tok_chain[NUM_BINS]),
    .ctl       (ctl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // Row of bins, token flowing toward higher keys
  for (genvar i = 0; i < NUM_BINS; i++) begin : g_bin
    csort_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (KEY_W'(i)),
      .ctl     (ctl),
      .tok_in  (tok_chain[i]),
      .tok_out (tok_chain[i+1]),
      .hit     (hits[i])
    );
  end

endmodule

@@ test/counting_sort_checker.sv @@
// Scoreboard for the counting sort engine: tracks counts, pointer and bins_in_use,
// predicts each drain result and compares it with the output transfers.
// Depends on csort_pkg for the payload types, widths and command codes.
module counting_sort_checker import csort_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_item,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               mismatches,
  output int               outstanding
);

  localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;

  logic [COUNT_BITS-1:0] key_tally [NUM_BINS];
  logic [KEY_W-1:0]      scan_start;
  logic [CFG_W-1:0]      bins_limit;
  out_item_t             sorted_q [$];

  // Update the tallies for one accepted command; queue the result of a drain
  task automatic apply_command(input in_item_t item);
    int        active_bins;
    int        b;
    bit        found;
    out_item_t res;
    active_bins = (int'(bins_limit) > NUM_BINS) ? NUM_BINS : int'(bins_limit);
    if (item.cmd == CMD_COUNT) begin
      if (int'(item.key) < active_bins) begin
        if (key_tally[item.key] != TALLY_MAX) key_tally[item.key]++;
        // a count below the pointer pulls the pointer back
        if (item.key < scan_start) scan_start = item.key;
      end
    end else begin
      found = 1'b0;
      res   = '0;
      // scan the whole store, not only the bins in use
      for (b = int'(scan_start); b < NUM_BINS; b++) begin
        if (!found && key_tally[b] != '0) begin
          key_tally[b]--;
          scan_start     = KEY_W'(b);
          res.sorted_key = KEY_W'(b);
          found          = 1'b1;
        end
      end
      if (!found) begin
        scan_start    = '0;
        res.empty_res = 1'b1;
      end
      sorted_q = {sorted_q, res};
    end
  endtask

  // Compare one output transfer with the oldest predicted result
  task automatic check_result();
    out_item_t want;
    if (sorted_q.size() == 0) begin
      $error("unexpected result: sorted_key %0d empty_res %0b",
             out_item.sorted_key, out_item.empty_res);
      mismatches++;
    end else begin
      want = sorted_q.pop_front();
      if (out_item.sorted_key !== want.sorted_key) begin
        $error("sorted_key: expected %0d, got %0d", want.sorted_key, out_item.sorted_key);
        mismatches++;
      end
      if (out_item.empty_res !== want.empty_res) begin
        $error("empty_res: expected %0b, got %0b", want.empty_res, out_item.empty_res);
        mismatches++;
      end
    end
  endtask

  // Sample all channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      foreach (key_tally[i]) key_tally[i] = '0;
      scan_start = '0;
      bins_limit = BINS_RESET;
      sorted_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) bins_limit = cfg_wdata;
      if (in_valid && in_ready) apply_command(in_item);
      if (out_valid && out_ready) check_result();
    end
    outstanding = sorted_q.size();
  end

endmodule

@@ test/tb_counting_sort_engine_top.sv @@
// Testbench top for counting_sort_engine_top: clock, reset, stimulus and verdict.
// Depends on csort_pkg, the engine RTL and counting_sort_checker.
module tb_counting_sort_engine_top;
  import csort_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int PHASE_QUOTA  = 228;
  localparam int SCAN_SETTLE  = NUM_BINS + 8;

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_item;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = BINS_RESET;

  int mismatches;
  int outstanding;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int bins_now       = int'(BINS_RESET);
  int items_sent     = 0;
  int drains_sent    = 0;
  int settings_used  = 0;
  int cycle_count    = 0;

  counting_sort_engine_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  counting_sort_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_counting_sort_engine_top failed");
      $finish;
    end
  end

  function automatic int active_bins();
    return (bins_now > NUM_BINS) ? NUM_BINS : bins_now;
  endfunction

  // Mostly keys in range, some anywhere in the key field
  function automatic logic [KEY_W-1:0] pick_key();
    if (active_bins() == 0 || $urandom_range(0, 9) == 0) return KEY_W'($urandom);
    return KEY_W'($urandom_range(0, active_bins() - 1));
  endfunction

  // Present one command and hold it until the transfer; called at a falling edge
  task automatic push_item(input logic cmd, input logic [KEY_W-1:0] key);
    in_item_t item;
    item.cmd = cmd;
    item.key = key;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (cmd == CMD_DRAIN) drains_sent++;
    items_sent++;
  endtask

  // Drop valid, wait for every result, then cover a full scan
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SCAN_SETTLE) @(negedge clk);
  endtask

  task automatic write_bins(input int value);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    @(negedge clk);
    cfg_we   <= 1'b0;
    bins_now  = value;
    settings_used++;
  endtask

  // Bursts of counts followed by drains, mixed with random commands
  task automatic run_phase(input int quota);
    int goal;
    int burst;
    goal = items_sent + quota;
    while (items_sent < goal) begin
      if ($urandom_range(0, 4) != 0) begin
        burst = $urandom_range(1, 12);
        repeat (burst) push_item(CMD_COUNT, pick_key());
        repeat (burst + $urandom_range(0, 2)) push_item(CMD_DRAIN, KEY_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) push_item(logic'($urandom_range(0, 1)), pick_key());
      end
    end
  endtask

  initial begin
    int idle_mix [4][2];
    int bins_plan [8];
    idle_mix  = '{'{0, 0}, '{56, 0}, '{0, 56}, '{34, 34}};
    bins_plan = '{128, 100, 255, 64, 1, 0, 17, 128};

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset setting: empty drain, out-of-range keys, pointer pulled back
    push_item(CMD_DRAIN, '0);
    push_item(CMD_COUNT, KEY_W'(0));
    push_item(CMD_COUNT, KEY_W'(127));
    push_item(CMD_COUNT, KEY_W'(99));
    push_item(CMD_COUNT, KEY_W'(100));
    push_item(CMD_COUNT, KEY_W'(50));
    push_item(CMD_COUNT, KEY_W'(50));
    push_item(CMD_DRAIN, '1);
    push_item(CMD_DRAIN, '0);
    push_item(CMD_COUNT, KEY_W'(20));
    push_item(CMD_DRAIN, '0);
    push_item(CMD_DRAIN, '0);
    push_item(CMD_DRAIN, '0);
    push_item(CMD_DRAIN, '0);
    settle();

    // Zero bins: every count is dropped
    write_bins(0);
    push_item(CMD_COUNT, KEY_W'(5));
    push_item(CMD_DRAIN, '0);
    settle();

    // Oversized setting, then shrink and drain the bins left above it
    write_bins(255);
    push_item(CMD_COUNT, KEY_W'(127));
    push_item(CMD_COUNT, KEY_W'(120));
    settle();
    write_bins(1);
    push_item(CMD_COUNT, KEY_W'(0));
    push_item(CMD_COUNT, KEY_W'(1));
    push_item(CMD_DRAIN, '0);
    push_item(CMD_DRAIN, '0);
    push_item(CMD_DRAIN, '0);
    push_item(CMD_DRAIN, '0);
    settle();

    // Random phases across settings and idle mixes
    for (int p = 0; p < 8; p++) begin
      src_idle_pct   = idle_mix[p % 4][0];
      sink_stall_pct = idle_mix[p % 4][1];
      write_bins(bins_plan[p]);
      run_phase(PHASE_QUOTA);
      settle();
    end

    $display("summary: %0d commands (%0d drains) under %0d bins_in_use settings,",
             items_sent, drains_sent, settings_used);
    $display("         four idle mixes, %0d cycles", cycle_count);
    if (mismatches == 0) begin
      $display("tb_counting_sort_engine_top passed");
    end else begin
      $display("tb_counting_sort_engine_top failed");
    end
    $finish;
  end

endmodule
